/* hdl/drr_pkg.sv */
// constants, codes and small helper functions of the deficit round robin scheduler
// no dependencies; imported by deficit_round_robin_scheduler
package drr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 3;

    localparam int CLS_W   = 2;
    localparam int LEN_W   = 16;
    localparam int QUANT_W = 16;
    localparam int WGT_W   = 8;
    localparam int CREDIT_W = QUANT_W + WGT_W;
    localparam int DEF_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CMD_W   = 1;
    localparam int REG_W   = 2;

    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);

    // quotient of a length by a credit, visit count and credit product
    localparam int Q_W    = LEN_W;
    localparam int VIS_W  = Q_W + 1;
    localparam int PROD_W = VIS_W + CREDIT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int T_W    = Q_W + 2;
    localparam int REM_W  = CREDIT_W + 1;
    localparam int DCNT_W = $clog2(LEN_W);

    localparam int IN_TDATA_W  = ((CLS_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CLS_W + LEN_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_ENQ    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DROP   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SERVED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd3;

    localparam logic [REG_W-1:0] REG_QUANTUM = 2'd0;
    localparam logic [REG_W-1:0] REG_WEIGHT0 = 2'd1;
    localparam logic [REG_W-1:0] REG_WEIGHT1 = 2'd2;
    localparam logic [REG_W-1:0] REG_WEIGHT2 = 2'd3;

    localparam logic [CLS_W-1:0] CLS_UNMATCHED = 2'd3;
    localparam logic [CLS_W-1:0] CLS_LAST      = CLS_W'(NUM_CLASSES - 1);

    localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd1500;
    localparam logic [WGT_W-1:0]   WEIGHT_RST  = 8'd1;

    typedef logic [CLS_W-1:0] t_cls;

    // distance from the round pointer to class c, in visits
    function automatic t_cls cls_off(input t_cls c, input t_cls rp);
        logic [CLS_W:0] s;
        s = {1'b0, c} + (CLS_W + 1)'(NUM_CLASSES) - {1'b0, rp};
        if (s >= (CLS_W + 1)'(NUM_CLASSES)) begin
            s = s - (CLS_W + 1)'(NUM_CLASSES);
        end
        return s[CLS_W-1:0];
    endfunction

    function automatic t_cls cls_next(input t_cls c);
        return (c == CLS_LAST) ? '0 : c + 1'b1;
    endfunction

endpackage

/* hdl/drr_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module drr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/deficit_round_robin_scheduler.sv */
// deficit round robin scheduler over three class queues of packet lengths
// enqueue: the word is registered, then the ram write and the result register are updated
//   together once the result slot is free; dequeue: per class a head read and a credit
//   check, plus a bit-serial divider pass for a class whose head needs a quotient, then
//   selection and, for a served head, deficit update through the shared multiplier
// one word in flight; the input is ready again once the result of the last word is registered
// synchronous active-low reset clears counts, deficits, pointer and reloads registers;
//   the queue ram is not cleared
module deficit_round_robin_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [drr_pkg::IN_TDATA_W-1:0] i_s_tdata,   // class_index, packet_length
    input  logic                           i_s_tuser,   // cmd
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [drr_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // served_class, served_length
    output logic [drr_pkg::STAT_W-1:0]     o_m_tuser,   // status
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [drr_pkg::REG_W-1:0]      i_cfg_index,
    input  logic [drr_pkg::QUANT_W-1:0]    i_cfg_data
);
    import drr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ENQ  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SEL  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // control state
    logic [3:0]        r_state, n_state;
    t_cls              r_cls, n_cls;
    logic [HEAD_W-1:0] r_head [NUM_CLASSES];
    logic [HEAD_W-1:0] n_head [NUM_CLASSES];
    logic [CNT_W-1:0]  r_count [NUM_CLASSES];
    logic [CNT_W-1:0]  n_count [NUM_CLASSES];
    logic [DEF_W-1:0]  r_deficit [NUM_CLASSES];
    logic [DEF_W-1:0]  n_deficit [NUM_CLASSES];
    t_cls              r_rp, n_rp;
    logic [QUANT_W-1:0] r_quantum, n_quantum;
    logic [WGT_W-1:0]  r_weight [NUM_CLASSES];
    logic [WGT_W-1:0]  n_weight [NUM_CLASSES];
    logic              r_out_valid, n_out_valid;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    // payload
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    t_cls                r_in_cls, n_in_cls;
    logic [LEN_W-1:0]    r_in_len, n_in_len;
    logic [CREDIT_W-1:0] r_credit [NUM_CLASSES];
    logic [CREDIT_W-1:0] n_credit [NUM_CLASSES];
    logic [LEN_W-1:0]    r_need [NUM_CLASSES];
    logic [LEN_W-1:0]    n_need [NUM_CLASSES];
    logic [Q_W-1:0]      r_q [NUM_CLASSES];
    logic [Q_W-1:0]      n_q [NUM_CLASSES];
    logic                r_ok [NUM_CLASSES];
    logic                n_ok [NUM_CLASSES];
    t_cls                r_best, n_best;
    logic [Q_W-1:0]      r_bestq, n_bestq;
    logic [STAT_W-1:0]   r_res, n_res;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [Q_W-1:0]      r_quo, n_quo;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    t_cls                r_out_class, n_out_class;
    logic [LEN_W-1:0]    r_out_len, n_out_len;

    // shared multiplier
    logic [VIS_W-1:0]    mul_a;
    logic [CREDIT_W-1:0] mul_b;
    logic [PROD_W-1:0]   mul_p;

    // divider step
    logic [REM_W-1:0] div_sh;
    logic             div_ge;

    // ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LEN_W-1:0]  ram_rdata;

    // selection
    logic       sel_found;
    logic       sel_any;
    t_cls       sel_best;
    logic [T_W-1:0] sel_t;
    logic [T_W-1:0] cand_t;

    logic              slot_free;
    logic              s_accept;
    logic [CNT_W:0]    tail_sum;
    logic [HEAD_W-1:0] tail_ptr;
    logic [DEF_W:0]    chk_sum;
    logic [SUM_W-1:0]  acc_sum;
    t_cls              off_b;
    t_cls              off_c;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign slot_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(OUT_TDATA_W - CLS_W - LEN_W)'(0), r_out_len, r_out_class};

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_sh = {r_rem[REM_W-2:0], r_quo[Q_W-1]};
    assign div_ge = div_sh >= REM_W'(r_credit[r_cls]);

    assign tail_sum = (CNT_W + 1)'(r_head[r_in_cls]) + (CNT_W + 1)'(r_count[r_in_cls]);
    assign tail_ptr = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                    ? HEAD_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                    : HEAD_W'(tail_sum);

    assign ram_waddr = ADDR_W'(ADDR_W'(r_in_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ptr));
    assign ram_raddr = ADDR_W'(ADDR_W'(r_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[r_cls]));
    assign ram_we    = (r_state == S_ENQ) && slot_free
                    && (r_count[r_in_cls] < CNT_W'(QUEUE_DEPTH));

    assign chk_sum = (DEF_W + 1)'(r_deficit[r_cls]) + (DEF_W + 1)'(r_credit[r_cls]);
    assign off_b   = cls_off(r_best, r_rp);
    assign off_c   = cls_off(r_cls, r_rp);

    drr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_CLASSES * QUEUE_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_in_len),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // earliest serving visit: offset plus three visits per extra round
    always_comb begin
        sel_found = 1'b0;
        sel_any   = 1'b0;
        sel_best  = '0;
        sel_t     = '0;
        cand_t    = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cand_t = T_W'(cls_off(CLS_W'(c), r_rp)) + T_W'({r_q[c], 1'b0}) + T_W'(r_q[c]);
            if (r_count[c] != '0) begin
                sel_any = 1'b1;
            end
            if (r_ok[c] && (!sel_found || cand_t < sel_t)) begin
                sel_found = 1'b1;
                sel_t     = cand_t;
                sel_best  = CLS_W'(c);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cls        = r_cls;
        n_head       = r_head;
        n_count      = r_count;
        n_deficit    = r_deficit;
        n_rp         = r_rp;
        n_quantum    = r_quantum;
        n_weight     = r_weight;
        n_out_valid  = r_out_valid;
        n_dcnt       = r_dcnt;
        n_cmd        = r_cmd;
        n_in_cls     = r_in_cls;
        n_in_len     = r_in_len;
        n_credit     = r_credit;
        n_need       = r_need;
        n_q          = r_q;
        n_ok         = r_ok;
        n_best       = r_best;
        n_bestq      = r_bestq;
        n_res        = r_res;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_out_status = r_out_status;
        n_out_class  = r_out_class;
        n_out_len    = r_out_len;
        mul_a        = '0;
        mul_b        = '0;
        acc_sum      = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_QUANTUM: n_quantum   = i_cfg_data;
                REG_WEIGHT0: n_weight[0] = i_cfg_data[WGT_W-1:0];
                REG_WEIGHT1: n_weight[1] = i_cfg_data[WGT_W-1:0];
                REG_WEIGHT2: n_weight[2] = i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_cmd    = i_s_tuser;
                    n_in_len = i_s_tdata[CLS_W +: LEN_W];
                    n_in_cls = (i_s_tdata[CLS_W-1:0] == CLS_UNMATCHED)
                             ? CLS_LAST : i_s_tdata[CLS_W-1:0];
                    n_cls    = '0;
                    n_state  = (i_s_tuser == CMD_ENQ) ? S_ENQ : S_RD;
                end
            end
            S_ENQ: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_class = '0;
                    n_out_len   = '0;
                    if (r_count[r_in_cls] < CNT_W'(QUEUE_DEPTH)) begin
                        n_count[r_in_cls] = r_count[r_in_cls] + 1'b1;
                        n_out_status      = STAT_ENQ;
                    end else begin
                        n_out_status = STAT_DROP;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                mul_a           = VIS_W'(r_quantum);
                mul_b           = CREDIT_W'(r_weight[r_cls]);
                n_credit[r_cls] = mul_p[CREDIT_W-1:0];
                n_state         = S_CHK;
            end
            S_CHK: begin
                n_need[r_cls] = ram_rdata;
                n_q[r_cls]    = '0;
                n_ok[r_cls]   = 1'b0;
                if (r_count[r_cls] != '0 && chk_sum > (DEF_W + 1)'(ram_rdata)) begin
                    // head fits on the first visit
                    n_ok[r_cls] = 1'b1;
                    n_cls   = cls_next(r_cls);
                    n_state = (r_cls == CLS_LAST) ? S_SEL : S_RD;
                end else if (r_count[r_cls] != '0 && r_credit[r_cls] != '0) begin
                    // deficit is below the head length here, so it fits in LEN_W bits
                    n_ok[r_cls] = 1'b1;
                    n_rem   = '0;
                    n_quo   = ram_rdata - r_deficit[r_cls][LEN_W-1:0];
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    n_cls   = cls_next(r_cls);
                    n_state = (r_cls == CLS_LAST) ? S_SEL : S_RD;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? div_sh - REM_W'(r_credit[r_cls]) : div_sh;
                n_quo  = {r_quo[Q_W-2:0], div_ge};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCNT_W'(LEN_W - 1)) begin
                    n_q[r_cls] = {r_quo[Q_W-2:0], div_ge};
                    n_cls   = cls_next(r_cls);
                    n_state = (r_cls == CLS_LAST) ? S_SEL : S_RD;
                end
            end
            S_SEL: begin
                n_cls   = '0;
                n_best  = sel_best;
                n_bestq = r_q[sel_best];
                if (!sel_any) begin
                    n_rp    = cls_next(r_rp);
                    n_res   = STAT_NONE;
                    n_state = S_OUT;
                end else if (!sel_found) begin
                    n_res   = STAT_NONE;
                    n_state = S_OUT;
                end else begin
                    n_res   = STAT_SERVED;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // visits granted to this class up to and including the serving visit
                if (r_cls == r_best) begin
                    mul_a = VIS_W'(r_bestq) + 1'b1;
                end else if (r_count[r_cls] != '0) begin
                    mul_a = VIS_W'(r_bestq) + VIS_W'(off_b > off_c);
                end else begin
                    mul_a = '0;
                end
                mul_b   = r_credit[r_cls];
                n_prod  = mul_p;
                n_state = S_ACC;
            end
            S_ACC: begin
                acc_sum = SUM_W'(r_deficit[r_cls]) + SUM_W'(r_prod);
                if (r_cls == r_best) begin
                    acc_sum = acc_sum - SUM_W'(r_need[r_cls]);
                end
                n_deficit[r_cls] = (|acc_sum[SUM_W-1:DEF_W]) ? '1 : acc_sum[DEF_W-1:0];
                n_cls   = cls_next(r_cls);
                n_state = (r_cls == CLS_LAST) ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_out_class  = '0;
                    n_out_len    = '0;
                    if (r_res == STAT_SERVED) begin
                        n_out_class     = r_best;
                        n_out_len       = r_need[r_best];
                        n_head[r_best]  = (r_head[r_best] == HEAD_W'(QUEUE_DEPTH - 1))
                                        ? '0 : r_head[r_best] + 1'b1;
                        n_count[r_best] = r_count[r_best] - 1'b1;
                        n_rp            = cls_next(r_best);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cls       <= '0;
            r_rp        <= '0;
            r_quantum   <= QUANTUM_RST;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]    <= '0;
                r_count[c]   <= '0;
                r_deficit[c] <= '0;
                r_weight[c]  <= WEIGHT_RST;
            end
        end else begin
            r_state     <= n_state;
            r_cls       <= n_cls;
            r_rp        <= n_rp;
            r_quantum   <= n_quantum;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
            r_head      <= n_head;
            r_count     <= n_count;
            r_deficit   <= n_deficit;
            r_weight    <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_in_cls     <= n_in_cls;
        r_in_len     <= n_in_len;
        r_credit     <= n_credit;
        r_need       <= n_need;
        r_q          <= n_q;
        r_ok         <= n_ok;
        r_best       <= n_best;
        r_bestq      <= n_bestq;
        r_res        <= n_res;
        r_prod       <= n_prod;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_out_status <= n_out_status;
        r_out_class  <= n_out_class;
        r_out_len    <= n_out_len;
    end

endmodule

/* test/deficit_round_robin_scheduler_tb.sv */
// self-checking testbench for the deficit round robin scheduler: directed, random and
// saturation phases under several register settings, with random stalls on both streams
// depends on hdl/drr_pkg.sv and hdl/deficit_round_robin_scheduler.sv
module deficit_round_robin_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PRESSURE_AFTER = 200;
    localparam int unsigned PRESSURE_LEN   = 600;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CLS_W-1:0]  cls;
        logic [LEN_W-1:0]  len;
    } drr_outcome_t;

    // tracks queues, deficits and round pointer, and holds the outcomes still owed
    class drr_scoreboard;
        logic [LEN_W-1:0]   ring [NUM_CLASSES][QUEUE_DEPTH];
        int unsigned        head [NUM_CLASSES];
        int unsigned        count [NUM_CLASSES];
        logic [DEF_W-1:0]   deficit [NUM_CLASSES];
        int unsigned        rp;
        logic [QUANT_W-1:0] quantum;
        logic [WGT_W-1:0]   weight [NUM_CLASSES];
        drr_outcome_t       owed_outcomes [$];
        int unsigned        mismatches;
        int unsigned        n_checked;
        int unsigned        n_enq;
        int unsigned        n_drop;
        int unsigned        n_served;
        int unsigned        n_none;

        function new();
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head[c]    = 0;
                count[c]   = 0;
                deficit[c] = '0;
                weight[c]  = WEIGHT_RST;
            end
            rp         = 0;
            quantum    = QUANTUM_RST;
            mismatches = 0;
            n_checked  = 0;
            n_enq      = 0;
            n_drop     = 0;
            n_served   = 0;
            n_none     = 0;
        endfunction

        function void write_reg(logic [REG_W-1:0] idx, logic [QUANT_W-1:0] data);
            case (idx)
                REG_QUANTUM: quantum   = data;
                REG_WEIGHT0: weight[0] = data[WGT_W-1:0];
                REG_WEIGHT1: weight[1] = data[WGT_W-1:0];
                REG_WEIGHT2: weight[2] = data[WGT_W-1:0];
                default: ;
            endcase
        endfunction

        function drr_outcome_t predict_outcome(logic [CMD_W-1:0] cmd, logic [CLS_W-1:0] cls_in,
                                               logic [LEN_W-1:0] len);
            drr_outcome_t      res;
            int unsigned       cls;
            int unsigned       off;
            int unsigned       best;
            bit                any_nonempty;
            bit                found;
            longint unsigned   credit;
            longint unsigned   need;
            longint unsigned   k;
            longint unsigned   t;
            longint unsigned   best_t;
            longint unsigned   visits;
            longint unsigned   sum;
            logic [LEN_W-1:0]  h;
            res          = '0;
            any_nonempty = 1'b0;
            found        = 1'b0;
            best         = 0;
            best_t       = 0;
            if (cmd == CMD_ENQ) begin
                cls = (cls_in == CLS_UNMATCHED) ? int'(CLS_LAST) : int'(cls_in);
                if (count[cls] >= QUEUE_DEPTH) begin
                    res.status = STAT_DROP;
                    return res;
                end
                ring[cls][(head[cls] + count[cls]) % QUEUE_DEPTH] = len;
                count[cls]++;
                res.status = STAT_ENQ;
                return res;
            end

            // earliest visit, counted from the round pointer, that can serve a head
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (count[c] == 0) continue;
                any_nonempty = 1'b1;
                credit = 64'(quantum) * 64'(weight[c]);
                need   = 64'(ring[c][head[c]]);
                off    = (c + NUM_CLASSES - rp) % NUM_CLASSES;
                if (64'(deficit[c]) + credit > need) begin
                    k = 1;
                end else if (credit == 0) begin
                    continue;
                end else begin
                    k = (need - 64'(deficit[c])) / credit + 1;
                end
                t = off + NUM_CLASSES * (k - 1);
                if (!found || t < best_t) begin
                    found  = 1'b1;
                    best_t = t;
                    best   = c;
                end
            end

            if (!any_nonempty) begin
                rp = (rp + 1) % NUM_CLASSES;
                res.status = STAT_NONE;
                return res;
            end
            if (!found) begin
                res.status = STAT_NONE;
                return res;
            end

            // other non-empty classes keep the credit of the visits passed over
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (c == best || count[c] == 0) continue;
                off    = (c + NUM_CLASSES - rp) % NUM_CLASSES;
                visits = (best_t > off) ? (best_t - off + NUM_CLASSES - 1) / NUM_CLASSES : 0;
                sum    = 64'(deficit[c]) + visits * 64'(quantum) * 64'(weight[c]);
                deficit[c] = (sum > 64'hFFFF_FFFF) ? '1 : DEF_W'(sum);
            end

            credit = 64'(quantum) * 64'(weight[best]);
            k      = best_t / NUM_CLASSES + 1;
            h      = ring[best][head[best]];
            sum    = 64'(deficit[best]) + k * credit - 64'(h);
            deficit[best] = (sum > 64'hFFFF_FFFF) ? '1 : DEF_W'(sum);
            head[best]    = (head[best] + 1) % QUEUE_DEPTH;
            count[best]--;
            rp = int'((rp + best_t + 1) % NUM_CLASSES);
            res.status = STAT_SERVED;
            res.cls    = CLS_W'(best);
            res.len    = h;
            return res;
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic [CLS_W-1:0] cls,
                                 logic [LEN_W-1:0] len);
            drr_outcome_t res;
            res = predict_outcome(cmd, cls, len);
            owed_outcomes.push_back(res);
            case (res.status)
                STAT_ENQ:    n_enq++;
                STAT_DROP:   n_drop++;
                STAT_SERVED: n_served++;
                default:     n_none++;
            endcase
        endfunction

        function void report_mismatch(string what, drr_outcome_t want, drr_outcome_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: status exp %0d got %0d, class exp %0d got %0d, length exp %0d got %0d",
                         what, want.status, got.status, want.cls, got.cls, want.len, got.len);
            end
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [OUT_TDATA_W-1:0] tdata);
            drr_outcome_t want;
            drr_outcome_t got;
            got.status = status;
            got.cls    = tdata[CLS_W-1:0];
            got.len    = tdata[CLS_W +: LEN_W];
            n_checked++;
            if (owed_outcomes.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
                return;
            end
            want = owed_outcomes.pop_front();
            if (want !== got) report_mismatch("mismatch", want, got);
        endfunction

        function void flag_leftovers();
            while (owed_outcomes.size() != 0) begin
                report_mismatch("missing word", owed_outcomes.pop_front(), '0);
            end
        endfunction

        function int unsigned pending();
            return owed_outcomes.size();
        endfunction

        function int unsigned queued_total();
            return count[0] + count[1] + count[2];
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic [STAT_W-1:0]       o_m_tuser;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [REG_W-1:0]        i_cfg_index;
    logic [QUANT_W-1:0]      i_cfg_data;

    drr_scoreboard sb;
    bit            no_idle;
    int unsigned   cfg_writes;

    deficit_round_robin_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly back to back, sometimes a short gap, now and then a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge where the word was taken
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CLS_W-1:0] cls,
                             input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tuser  <= cmd;
        i_s_tdata  <= IN_TDATA_W'({len, cls});
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, cls, len);
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [QUANT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // weights go out with random upper bits, the block keeps only the low byte
    task automatic set_config(input logic [QUANT_W-1:0] q, input logic [WGT_W-1:0] w0,
                              input logic [WGT_W-1:0] w1, input logic [WGT_W-1:0] w2);
        stop_sending();
        drain_results();
        write_reg(REG_QUANTUM, q);
        write_reg(REG_WEIGHT0, {8'($urandom_range(0, 255)), w0});
        write_reg(REG_WEIGHT1, {8'($urandom_range(0, 255)), w1});
        write_reg(REG_WEIGHT2, {8'($urandom_range(0, 255)), w2});
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned enq_pct);
        logic [CLS_W-1:0] cls;
        logic [LEN_W-1:0] len;
        int unsigned      r;
        repeat (n_items) begin
            cls = $urandom_range(0, 3);
            r   = $urandom_range(0, 99);
            if (r < 10) len = '0;
            else if (r < 20) len = '1;
            else if (r < 60) len = $urandom_range(0, 3000);
            else len = $urandom_range(0, 65535);
            if ($urandom_range(0, 99) < enq_pct) send_word(CMD_ENQ, cls, len);
            else send_word(CMD_DEQ, cls, len);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
    end

    // result side: random stalls plus one long hold-off while the sender keeps going
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          pressure_done;
        stall_left    = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        i_m_tready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!pressure_done && sb.n_checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_LEN - 1;
                i_m_tready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        sb          = new();
        no_idle     = 1'b0;
        cfg_writes  = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_ENQ;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_QUANTUM;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty dequeue, length extremes, unmatched class, long credit build-up
        send_word(CMD_DEQ, 2'd0, 16'd0);
        send_word(CMD_ENQ, 2'd0, 16'd0);
        send_word(CMD_ENQ, 2'd1, 16'hFFFF);
        send_word(CMD_ENQ, CLS_UNMATCHED, 16'd1000);
        send_word(CMD_ENQ, 2'd2, 16'd1499);
        send_word(CMD_ENQ, 2'd2, 16'd1500);
        repeat (6) send_word(CMD_DEQ, 2'd3, 16'hFFFF);

        // overfill the last class through the unmatched index
        repeat (18) send_word(CMD_ENQ, CLS_UNMATCHED, $urandom_range(0, 65535));

        set_config(16'd1500, 8'd1, 8'd2, 8'd3);
        run_random_phase(110, 55);
        set_config(16'd1, 8'd1, 8'd1, 8'd1);
        run_random_phase(100, 50);
        set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        no_idle = 1'b1;
        run_random_phase(110, 60);
        no_idle = 1'b0;
        set_config($urandom_range(1, 65535), $urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 255));
        run_random_phase(110, 50);
        // no class earns credit
        set_config(16'd0, 8'd3, 8'd5, 8'd7);
        run_random_phase(40, 60);
        // class one earns nothing, the others do
        set_config(16'd700, $urandom_range(1, 255), 8'd0, $urandom_range(1, 255));
        run_random_phase(110, 50);
        set_config($urandom_range(1, 64), $urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 255));
        run_random_phase(100, 45);

        // serve short packets of one class under maximum credit until its deficit saturates
        set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        while (sb.queued_total() != 0) begin
            send_word(CMD_DEQ, $urandom_range(0, 3), $urandom_range(0, 65535));
        end
        no_idle = 1'b1;
        repeat (20) begin
            repeat (16) send_word(CMD_ENQ, 2'd0, $urandom_range(0, 255));
            repeat (16) send_word(CMD_DEQ, $urandom_range(0, 3), $urandom_range(0, 65535));
        end
        no_idle = 1'b0;
        run_random_phase(30, 50);

        stop_sending();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        sb.flag_leftovers();

        $display("covered %0d enqueues, %0d drops, %0d serves and %0d empty replies",
                 sb.n_enq, sb.n_drop, sb.n_served, sb.n_none);
        $display("%0d register writes over eight settings, %0d mismatches",
                 cfg_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
